// ----- design/rgb_led_strip_frame_encoder_top_assert.svh -----
// Assertion macros used by the checker file of the LED strip encoder.
`ifndef RGB_LED_STRIP_FRAME_ENCODER_TOP_ASSERT_SVH
`define RGB_LED_STRIP_FRAME_ENCODER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define RGBLED_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgb led strip encoder: check failed");

// Next-cycle implication, disabled while reset is low.
`define RGBLED_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgb led strip encoder: check failed");

`endif

// ----- design/rgbled_pkg.sv -----
`default_nettype none
package rgbled_pkg;

    localparam int unsigned LED_COUNT  = 64;
    localparam int unsigned HEAD_SLOTS = 300;
    localparam int unsigned TAIL_SLOTS = 200;

    localparam int unsigned LED_BITS    = 24;
    localparam int unsigned DATA_SLOTS  = LED_COUNT * LED_BITS;
    localparam int unsigned FRAME_SLOTS = HEAD_SLOTS + DATA_SLOTS + TAIL_SLOTS;
    localparam int unsigned SLOT_W      = $clog2(FRAME_SLOTS);
    localparam int unsigned LED_AW      = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int unsigned LED_CW      = $clog2(LED_COUNT + 1);
    localparam int unsigned BIT_W       = $clog2(LED_BITS);

    localparam int unsigned OP_W      = 2;
    localparam int unsigned IDX_W     = 16;
    localparam int unsigned CH_W      = 8;
    localparam int unsigned CMP_W     = 16;
    localparam int unsigned PCT_W     = 7;
    localparam int unsigned PCT_FULL  = 100;
    localparam int unsigned CFG_IDX_W = 2;

    // Division by 100 through a reciprocal: exact for products below 25600.
    localparam int unsigned PROD_W      = CH_W + PCT_W;
    localparam int unsigned RECIP_SHIFT = 19;
    localparam int unsigned RECIP       = ((1 << RECIP_SHIFT) + PCT_FULL - 1) / PCT_FULL;
    localparam int unsigned RECIP_W     = 13;
    localparam int unsigned QMUL_W      = PROD_W + RECIP_W;

    localparam logic [OP_W-1:0] OP_SET_PIXEL = 2'd0;
    localparam logic [OP_W-1:0] OP_SET_ALL   = 2'd1;
    localparam logic [OP_W-1:0] OP_REFRESH   = 2'd2;
    localparam logic [OP_W-1:0] OP_TICK      = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_CMP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_CMP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PCT      = 2'd2;

    typedef logic [LED_BITS-1:0] t_grb;

    typedef struct packed {
        logic              write;
        logic              fill;
        logic [LED_AW-1:0] addr;
        t_grb              word;
    } t_store_cmd;

endpackage
`default_nettype wire

// ----- design/rgbled_scale.sv -----
`default_nettype none
// Three-lane brightness scaler: multiply by percent, then divide by 100
// through a reciprocal multiply. Two register stages.
module rgbled_scale (
    input  wire logic                         i_clk,
    input  wire logic [rgbled_pkg::CH_W-1:0]  i_red,
    input  wire logic [rgbled_pkg::CH_W-1:0]  i_green,
    input  wire logic [rgbled_pkg::CH_W-1:0]  i_blue,
    input  wire logic [rgbled_pkg::PCT_W-1:0] i_pct,
    output rgbled_pkg::t_grb                  o_grb
);

    logic [rgbled_pkg::PROD_W-1:0] r_prod [3];
    logic [rgbled_pkg::CH_W-1:0]   r_quo  [3];
    logic [rgbled_pkg::CH_W-1:0]   chan   [3];
    logic [rgbled_pkg::QMUL_W-1:0] qmul   [3];

    assign chan[0] = i_green;
    assign chan[1] = i_red;
    assign chan[2] = i_blue;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            qmul[k] = rgbled_pkg::QMUL_W'(r_prod[k])
                    * rgbled_pkg::QMUL_W'(rgbled_pkg::RECIP);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_prod[k] <= rgbled_pkg::PROD_W'(chan[k]) * rgbled_pkg::PROD_W'(i_pct);
            r_quo[k]  <= qmul[k][rgbled_pkg::RECIP_SHIFT +: rgbled_pkg::CH_W];
        end
    end

    assign o_grb = {r_quo[0], r_quo[1], r_quo[2]};

endmodule
`default_nettype wire

// ----- design/rgbled_store.sv -----
`default_nettype none
// Pixel store: one synchronous RAM, per-entry valid bits and a fill word.
// An entry that is not valid reads as the fill word, so set-all only
// loads the fill word and drops every valid bit.
module rgbled_store (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire rgbled_pkg::t_store_cmd        i_cmd,
    input  wire logic [rgbled_pkg::LED_AW-1:0] i_rd_addr,
    output rgbled_pkg::t_grb                   o_rd_word
);

    rgbled_pkg::t_grb                     mem [rgbled_pkg::LED_COUNT];
    logic [rgbled_pkg::LED_COUNT-1:0]     r_valid;
    rgbled_pkg::t_grb                     r_fill;
    rgbled_pkg::t_grb                     r_mem_q;
    logic                                 r_valid_q;

    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            mem[i_cmd.addr] <= i_cmd.word;
        end
        r_mem_q <= mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_fill    <= '0;
            r_valid_q <= 1'b0;
        end else begin
            r_valid_q <= r_valid[i_rd_addr];
            if (i_cmd.fill) begin
                r_valid <= '0;
                r_fill  <= i_cmd.word;
            end else if (i_cmd.write) begin
                r_valid[i_cmd.addr] <= 1'b1;
            end
        end
    end

    assign o_rd_word = r_valid_q ? r_mem_q : r_fill;

endmodule
`default_nettype wire

// ----- design/rgb_led_strip_frame_encoder_top.sv -----
`default_nettype none
// Channel    | Handshake               | Payload
// -----------+-------------------------+-------------------------------------------
// request    | start / busy            | i_opcode, i_led_index, i_red/green/blue
// result     | o_valid (one cycle)     | o_status, o_compare_value, o_slot_valid,
//            |                         | o_frame_done, o_sending
// config     | i_cfg_we                | i_cfg_index, i_cfg_data
//
// A request is taken on a clock edge where start is high and busy is low.
// Refresh and a tick while no frame is active answer in the next cycle.
// A tick during a frame answers from the tick state, with the store word that was read
// as the request was taken. Set-pixel and set-all pass the states MUL, DIV and WR, set
// by the two-stage scaler and the store write. Busy is high until the answer is registered.
// Reset is synchronous and active low and blanks the store at once; results cannot stall.
module rgb_led_strip_frame_encoder_top (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output      logic                             busy,
    input  wire logic [rgbled_pkg::OP_W-1:0]      i_opcode,
    input  wire logic [rgbled_pkg::IDX_W-1:0]     i_led_index,
    input  wire logic [rgbled_pkg::CH_W-1:0]      i_red,
    input  wire logic [rgbled_pkg::CH_W-1:0]      i_green,
    input  wire logic [rgbled_pkg::CH_W-1:0]      i_blue,
    input  wire logic                             i_cfg_we,
    input  wire logic [rgbled_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [rgbled_pkg::CMP_W-1:0]     i_cfg_data,
    output      logic                             o_valid,
    output      logic                             o_status,
    output      logic [rgbled_pkg::CMP_W-1:0]     o_compare_value,
    output      logic                             o_slot_valid,
    output      logic                             o_frame_done,
    output      logic                             o_sending
);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_WR   = 3'd3;
    localparam logic [2:0] ST_TICK = 3'd4;

    localparam int unsigned SW = rgbled_pkg::SLOT_W;
    localparam logic [SW-1:0] DATA_START = SW'(rgbled_pkg::HEAD_SLOTS);
    localparam logic [SW-1:0] DATA_END   =
        SW'(rgbled_pkg::HEAD_SLOTS + rgbled_pkg::DATA_SLOTS);
    localparam logic [SW-1:0] LAST_SLOT  = SW'(rgbled_pkg::FRAME_SLOTS - 1);
    localparam logic [rgbled_pkg::BIT_W-1:0] LAST_BIT =
        rgbled_pkg::BIT_W'(rgbled_pkg::LED_BITS - 1);

    logic [2:0] r_state, n_state;

    // Request payload, held while the request is worked on.
    logic [rgbled_pkg::OP_W-1:0]  r_op, n_op;
    logic [rgbled_pkg::IDX_W-1:0] r_idx, n_idx;
    logic [rgbled_pkg::CH_W-1:0]  r_red, n_red, r_green, n_green, r_blue, n_blue;

    // Configuration registers.
    logic [rgbled_pkg::CMP_W-1:0] r_zero_cmp, n_zero_cmp, r_one_cmp, n_one_cmp;
    logic [rgbled_pkg::PCT_W-1:0] r_pct, n_pct;

    // Frame position: the slot count plus the LED and bit it points at in the
    // data part of the frame, so no division by 24 is needed.
    logic [SW-1:0]                    r_slot, n_slot;
    logic [rgbled_pkg::LED_CW-1:0]    r_led, n_led;
    logic [rgbled_pkg::BIT_W-1:0]     r_bit, n_bit;
    logic                             r_active, n_active;

    // Result registers.
    logic                         r_valid, n_valid;
    logic                         r_status, n_status;
    logic [rgbled_pkg::CMP_W-1:0] r_cmp, n_cmp;
    logic                         r_slot_valid, n_slot_valid;
    logic                         r_frame_done, n_frame_done;

    rgbled_pkg::t_store_cmd store_cmd;
    rgbled_pkg::t_grb       scaled_grb;
    rgbled_pkg::t_grb       rd_word;
    logic                   in_data;
    logic                   in_range;

    rgbled_scale u_scale (
        .i_clk   (i_clk),
        .i_red   (r_red),
        .i_green (r_green),
        .i_blue  (r_blue),
        .i_pct   (r_pct),
        .o_grb   (scaled_grb)
    );

    // The store is read at the current LED every cycle; on a tick the word
    // is ready in the cycle after the request is taken.
    rgbled_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (store_cmd),
        .i_rd_addr (r_led[rgbled_pkg::LED_AW-1:0]),
        .o_rd_word (rd_word)
    );

    assign in_data  = (r_slot >= DATA_START) && (r_slot < DATA_END);
    assign in_range = r_idx < rgbled_pkg::IDX_W'(rgbled_pkg::LED_COUNT);

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_idx        = r_idx;
        n_red        = r_red;
        n_green      = r_green;
        n_blue       = r_blue;
        n_zero_cmp   = r_zero_cmp;
        n_one_cmp    = r_one_cmp;
        n_pct        = r_pct;
        n_slot       = r_slot;
        n_led        = r_led;
        n_bit        = r_bit;
        n_active     = r_active;
        n_valid      = 1'b0;
        n_status     = 1'b0;
        n_cmp        = '0;
        n_slot_valid = 1'b0;
        n_frame_done = 1'b0;
        store_cmd    = '0;

        // Configuration writes are expected only while no request is in flight.
        if (i_cfg_we) begin
            case (i_cfg_index)
                rgbled_pkg::CFG_ZERO_CMP: n_zero_cmp = i_cfg_data;
                rgbled_pkg::CFG_ONE_CMP:  n_one_cmp  = i_cfg_data;
                rgbled_pkg::CFG_PCT: begin
                    // A brightness above full scale in the low PCT_W bits saturates; higher bits are ignored.
                    if (i_cfg_data[rgbled_pkg::PCT_W-1:0] >
                        rgbled_pkg::PCT_W'(rgbled_pkg::PCT_FULL)) begin
                        n_pct = rgbled_pkg::PCT_W'(rgbled_pkg::PCT_FULL);
                    end else begin
                        n_pct = i_cfg_data[rgbled_pkg::PCT_W-1:0];
                    end
                end
                default: ;
            endcase
        end

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_op    = i_opcode;
                    n_idx   = i_led_index;
                    n_red   = i_red;
                    n_green = i_green;
                    n_blue  = i_blue;
                    case (i_opcode)
                        rgbled_pkg::OP_SET_PIXEL,
                        rgbled_pkg::OP_SET_ALL: begin
                            n_state = ST_MUL;
                        end
                        rgbled_pkg::OP_REFRESH: begin
                            // Restart the frame from its first head slot.
                            n_slot   = '0;
                            n_led    = '0;
                            n_bit    = '0;
                            n_active = 1'b1;
                            n_valid  = 1'b1;
                        end
                        rgbled_pkg::OP_TICK: begin
                            if (r_active) begin
                                n_state = ST_TICK;
                            end else begin
                                // A tick with no frame running sends nothing.
                                n_valid = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_MUL: n_state = ST_DIV;
            ST_DIV: n_state = ST_WR;
            ST_WR: begin
                n_state        = ST_IDLE;
                n_valid        = 1'b1;
                store_cmd.word = scaled_grb;
                store_cmd.addr = r_idx[rgbled_pkg::LED_AW-1:0];
                if (r_op == rgbled_pkg::OP_SET_ALL) begin
                    store_cmd.fill = 1'b1;
                end else if (in_range) begin
                    store_cmd.write = 1'b1;
                end else begin
                    n_status = 1'b1;
                end
            end
            ST_TICK: begin
                n_state      = ST_IDLE;
                n_valid      = 1'b1;
                n_slot_valid = 1'b1;
                // Bits go out most significant first: G, then R, then B.
                if (in_data) begin
                    n_cmp = rd_word[LAST_BIT - r_bit] ? r_one_cmp : r_zero_cmp;
                end
                if (r_slot == LAST_SLOT) begin
                    n_frame_done = 1'b1;
                    n_active     = 1'b0;
                    n_slot       = '0;
                    n_led        = '0;
                    n_bit        = '0;
                end else begin
                    n_slot = r_slot + 1'b1;
                    if (in_data) begin
                        if (r_bit == LAST_BIT) begin
                            n_bit = '0;
                            n_led = r_led + 1'b1;
                        end else begin
                            n_bit = r_bit + 1'b1;
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_zero_cmp <= '0;
            r_one_cmp  <= '0;
            r_pct      <= rgbled_pkg::PCT_W'(rgbled_pkg::PCT_FULL);
            r_slot     <= '0;
            r_led      <= '0;
            r_bit      <= '0;
            r_active   <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_zero_cmp <= n_zero_cmp;
            r_one_cmp  <= n_one_cmp;
            r_pct      <= n_pct;
            r_slot     <= n_slot;
            r_led      <= n_led;
            r_bit      <= n_bit;
            r_active   <= n_active;
            r_valid    <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_idx        <= n_idx;
        r_red        <= n_red;
        r_green      <= n_green;
        r_blue       <= n_blue;
        r_status     <= n_status;
        r_cmp        <= n_cmp;
        r_slot_valid <= n_slot_valid;
        r_frame_done <= n_frame_done;
    end

    assign busy            = (r_state != ST_IDLE);
    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_compare_value = r_cmp;
    assign o_slot_valid    = r_slot_valid;
    assign o_frame_done    = r_frame_done;
    assign o_sending       = r_active;

endmodule
`default_nettype wire

// ----- design/rgbled_checker.sv -----
`default_nettype none
`include "rgb_led_strip_frame_encoder_top_assert.svh"
// Port-level checks on the LED strip encoder.
module rgbled_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             start,
    input wire logic                             busy,
    input wire logic [rgbled_pkg::OP_W-1:0]      i_opcode,
    input wire logic [rgbled_pkg::IDX_W-1:0]     i_led_index,
    input wire logic [rgbled_pkg::CH_W-1:0]      i_red,
    input wire logic [rgbled_pkg::CH_W-1:0]      i_green,
    input wire logic [rgbled_pkg::CH_W-1:0]      i_blue,
    input wire logic                             i_cfg_we,
    input wire logic [rgbled_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input wire logic [rgbled_pkg::CMP_W-1:0]     i_cfg_data,
    input wire logic                             o_valid,
    input wire logic                             o_status,
    input wire logic [rgbled_pkg::CMP_W-1:0]     o_compare_value,
    input wire logic                             o_slot_valid,
    input wire logic                             o_frame_done,
    input wire logic                             o_sending
);

    logic accept;
    assign accept = start && !busy;

    // A refresh answers in the next cycle with the frame running.
    `RGBLED_ASSERT_NEXT(a_refresh_starts, i_clk, i_rst_n,
        accept && (i_opcode == rgbled_pkg::OP_REFRESH),
        o_valid && o_sending && !o_slot_valid)

    // Pixel writes go through the scaler, so the block stays busy.
    `RGBLED_ASSERT_NEXT(a_write_busy, i_clk, i_rst_n,
        accept && (i_opcode == rgbled_pkg::OP_SET_PIXEL ||
                   i_opcode == rgbled_pkg::OP_SET_ALL),
        busy && !o_valid)

    // Without a slot there is no compare value and no frame end.
    `RGBLED_ASSERT_NOW(a_no_slot_quiet, i_clk, i_rst_n,
        o_valid && !o_slot_valid,
        (o_compare_value == '0) && !o_frame_done)

    // The last tail slot ends the frame.
    `RGBLED_ASSERT_NOW(a_done_ends_frame, i_clk, i_rst_n,
        o_valid && o_frame_done,
        o_slot_valid && !o_sending && !o_status)

endmodule

bind rgb_led_strip_frame_encoder_top rgbled_checker u_checker (.*);
`default_nettype wire
